// File: sv/lkcd_pkg.sv
// Shared constants and types for the LRU keyed cache directory.
// No dependencies; imported by the top level.
package lkcd_pkg;

	localparam int DEF_MAX_ENTRIES = 32;
	localparam int DEF_KEY_WIDTH   = 32;

	localparam int CAPACITY_W = 6;
	localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 6'd30;

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DECIDE = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

endpackage

// File: sv/lru_keyed_cache_directory.sv
// Top level of the LRU keyed cache directory: sequencer, capacity register, output register.
// Depends on lkcd_pkg and lkcd_ram.
//
// Usage:
// A request item (lookup_key, force_refresh, fetch_ok) enters on the in_valid/in_ready
// channel. Exactly one result item leaves on the out_valid/out_ready channel for every
// request. The user must write the capacity register through cfg_write/cfg_data only while no
// request is in flight (the block itself does not enforce this); it takes effect on the next request.
// Keys live in a synchronous key RAM and recency ranks in a rank RAM, both with a registered
// read. A request first scans slots 0 to fill-1, reading key and rank of one slot per cycle,
// to find a hit and the least recent slot. A decision cycle then writes a new key if needed,
// and an update pass reads, adjusts and writes back the rank of every occupied slot, again
// one slot per cycle. Reads and writes in that pass are one slot apart, so no slot is read
// while its own write is pending. A failed miss skips the update pass.
// One request is handled at a time, and a new request is taken as soon as the previous
// result sits in the output register, even if the receiver has not yet taken it; a new
// request is not accepted before the previous one has finished. A stalled receiver holds the
// result and, once the next request has finished, holds back that request's completion
// until the register is free.
// Reset empties the directory (fill count zero) and sets capacity to 30.
module lru_keyed_cache_directory
	import lkcd_pkg::*;
#(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
	parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
	parameter int SLOT_W      = $clog2(MAX_ENTRIES)
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_write,
	input  logic [CAPACITY_W-1:0] cfg_data,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [KEY_WIDTH-1:0]  lookup_key,
	input  logic                  force_refresh,
	input  logic                  fetch_ok,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  was_hit,
	output logic [SLOT_W-1:0]     slot_index,
	output logic                  did_evict,
	output logic [KEY_WIDTH-1:0]  evicted_key,
	output logic                  contents_fetched,
	output logic                  failed
);

	localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W  = (FILL_W > CAPACITY_W) ? FILL_W : CAPACITY_W;

	state_t state_q;

	logic [CAPACITY_W-1:0] capacity_q;
	logic [FILL_W-1:0]     fill_q;
	logic [FILL_W-1:0]     idx_q;

	// Request being served.
	logic [KEY_WIDTH-1:0] key_q;
	logic                 force_q;
	logic                 ok_q;

	// Scan results.
	logic                 hit_q;
	logic [SLOT_W-1:0]    hit_slot_q;
	logic [SLOT_W-1:0]    hit_rank_q;
	logic [SLOT_W-1:0]    worst_slot_q;
	logic [SLOT_W-1:0]    worst_rank_q;
	logic [KEY_WIDTH-1:0] worst_key_q;

	// Read pipeline tracking for the scan and the update pass.
	logic                 rd_v_s1;
	logic [SLOT_W-1:0]    rd_idx_s1;

	// Decision for the update pass and the result.
	logic [SLOT_W-1:0]    slot_q;
	logic [FILL_W-1:0]    old_rank_q;
	logic                 res_hit_q;
	logic                 res_evict_q;
	logic [KEY_WIDTH-1:0] res_evkey_q;
	logic                 res_fetched_q;
	logic                 res_failed_q;

	// Output register.
	logic                 out_valid_q;
	logic                 out_hit_q;
	logic [SLOT_W-1:0]    out_slot_q;
	logic                 out_evict_q;
	logic [KEY_WIDTH-1:0] out_evkey_q;
	logic                 out_fetched_q;
	logic                 out_failed_q;

	// Memory ports.
	logic                 key_we;
	logic [SLOT_W-1:0]    key_waddr;
	logic [KEY_WIDTH-1:0] key_rdata;
	logic                 rank_we;
	logic [SLOT_W-1:0]    rank_wdata;
	logic [SLOT_W-1:0]    rank_rdata;
	logic [SLOT_W-1:0]    rd_addr;

	logic                 in_fire;
	logic                 issue;
	logic                 pass_done;
	logic                 out_load;
	logic                 key_match;
	logic                 worse;
	logic [CMP_W-1:0]     cap_ext;
	logic [CMP_W-1:0]     cap_eff;
	logic                 room;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign rd_addr   = idx_q[SLOT_W-1:0];
	assign issue     = ((state_q == ST_SCAN) || (state_q == ST_UPDATE)) && (idx_q != fill_q);
	assign pass_done = (idx_q == fill_q) && !rd_v_s1;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// Capacity of zero acts as one; capacity above the store size saturates.
	assign cap_ext = CMP_W'(capacity_q);
	always_comb begin
		if (cap_ext == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
			cap_eff = CMP_W'(MAX_ENTRIES);
		end else begin
			cap_eff = cap_ext;
		end
	end
	assign room = CMP_W'(fill_q) < cap_eff;

	// Scan compare on the data returned for the slot read in the previous cycle.
	assign key_match = rd_v_s1 && (state_q == ST_SCAN) && (key_rdata == key_q) && !hit_q;
	assign worse     = rank_rdata >= worst_rank_q;

	// Key RAM is written only in the decision cycle, for an allocation or an eviction.
	assign key_we    = (state_q == ST_DECIDE) && !hit_q && ok_q;
	assign key_waddr = room ? fill_q[SLOT_W-1:0] : worst_slot_q;

	// Rank write-back: the target slot becomes most recent, every occupied slot that was
	// more recent than the target's old rank ages by one.
	assign rank_we = rd_v_s1 && (state_q == ST_UPDATE);
	always_comb begin
		if (rd_idx_s1 == slot_q) begin
			rank_wdata = '0;
		end else if (FILL_W'(rank_rdata) < old_rank_q) begin
			rank_wdata = SLOT_W'(rank_rdata + 1'b1);
		end else begin
			rank_wdata = rank_rdata;
		end
	end

	lkcd_ram #(
		.DEPTH  (MAX_ENTRIES),
		.WIDTH  (KEY_WIDTH),
		.ADDR_W (SLOT_W)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_q),
		.raddr (rd_addr),
		.rdata (key_rdata)
	);

	lkcd_ram #(
		.DEPTH  (MAX_ENTRIES),
		.WIDTH  (SLOT_W),
		.ADDR_W (SLOT_W)
	) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (rd_idx_s1),
		.wdata (rank_wdata),
		.raddr (rd_addr),
		.rdata (rank_rdata)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			capacity_q  <= CAPACITY_RESET;
			fill_q      <= '0;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				capacity_q <= cfg_data;
			end

			rd_v_s1 <= issue;
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (key_match) begin
				hit_q <= 1'b1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						idx_q   <= '0;
						hit_q   <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (pass_done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					idx_q <= '0;
					if (!hit_q && !ok_q) begin
						state_q <= ST_DONE;
					end else begin
						if (!hit_q && room) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (pass_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr;

		if (in_fire) begin
			key_q        <= lookup_key;
			force_q      <= force_refresh;
			ok_q         <= fetch_ok;
			worst_rank_q <= '0;
			worst_slot_q <= '0;
			worst_key_q  <= '0;
		end

		if (rd_v_s1 && (state_q == ST_SCAN)) begin
			if (key_match) begin
				hit_slot_q <= rd_idx_s1;
				hit_rank_q <= rank_rdata;
			end
			if (worse) begin
				worst_rank_q <= rank_rdata;
				worst_slot_q <= rd_idx_s1;
				worst_key_q  <= key_rdata;
			end
		end

		if (state_q == ST_DECIDE) begin
			res_hit_q     <= hit_q;
			res_evict_q   <= 1'b0;
			res_evkey_q   <= '0;
			res_fetched_q <= 1'b0;
			res_failed_q  <= 1'b0;
			if (hit_q) begin
				slot_q        <= hit_slot_q;
				old_rank_q    <= FILL_W'(hit_rank_q);
				res_fetched_q <= force_q && ok_q;
				res_failed_q  <= force_q && !ok_q;
			end else if (!ok_q) begin
				// A failed miss reports only the failure and leaves the state alone.
				slot_q       <= '0;
				old_rank_q   <= '0;
				res_failed_q <= 1'b1;
			end else if (room) begin
				// New entry ranks behind every existing one before promotion.
				slot_q        <= fill_q[SLOT_W-1:0];
				old_rank_q    <= fill_q + 1'b1;
				res_fetched_q <= 1'b1;
			end else begin
				slot_q        <= worst_slot_q;
				old_rank_q    <= FILL_W'(worst_rank_q);
				res_evict_q   <= 1'b1;
				res_evkey_q   <= worst_key_q;
				res_fetched_q <= 1'b1;
			end
		end

		if (out_load) begin
			out_hit_q     <= res_hit_q;
			out_slot_q    <= slot_q;
			out_evict_q   <= res_evict_q;
			out_evkey_q   <= res_evkey_q;
			out_fetched_q <= res_fetched_q;
			out_failed_q  <= res_failed_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign was_hit          = out_hit_q;
	assign slot_index       = out_slot_q;
	assign did_evict        = out_evict_q;
	assign evicted_key      = out_evkey_q;
	assign contents_fetched = out_fetched_q;
	assign failed           = out_failed_q;

endmodule

// File: sv/lkcd_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// No dependencies; used for the key store and the recency rank store.
module lkcd_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
